>>> src/assert_macros.svh
// assertion helpers shared by the equalizer band gain filter modules
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/egbf_pkg.sv
// shared constants, codes and the raised-cosine weight rom
// for the equalizer band gain filter; no dependencies
package egbf_pkg;

  localparam int MAX_BANDS_DEF  = 16;
  localparam int FFT_POINTS     = 1024;
  localparam int SAMPLE_RATE_HZ = 48000;
  localparam int COS_TABLE_SIZE = 256;

  localparam int FFT_SHIFT = $clog2(FFT_POINTS);
  localparam int BIN_W     = 10;
  localparam int FREQ_W    = 15;
  localparam int GAIN_W    = 16;
  localparam int PART_W    = 28;
  localparam int VOL_W     = 16;
  localparam int FRAC_BITS = 12;
  localparam int W_W       = FRAC_BITS + 1;
  localparam int MUL_W     = 32;
  localparam int ACC_W     = GAIN_W + W_W + 1;
  localparam int NYQ_HZ    = SAMPLE_RATE_HZ / 2;

  // widest bin frequency, nyquist and table frequency all fit in F_W bits
  localparam int F_MAX = ((2 ** BIN_W - 1) * SAMPLE_RATE_HZ) / FFT_POINTS;
  localparam int F_W0  = $clog2(F_MAX + 1);
  localparam int F_W1  = ($clog2(NYQ_HZ + 1) > F_W0) ? $clog2(NYQ_HZ + 1) : F_W0;
  localparam int F_W   = (F_W1 > FREQ_W) ? F_W1 : FREQ_W;
  localparam int BP_W  = BIN_W + $clog2(SAMPLE_RATE_HZ + 1);

  localparam logic [W_W-1:0]    UNITY_W    = W_W'(4096);
  localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(4096);

  // register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME = 2'd2;

  localparam logic [1:0] SHAPE_RECT   = 2'd0;
  localparam logic [1:0] SHAPE_LINEAR = 2'd1;
  localparam logic [1:0] SHAPE_COSINE = 2'd2;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_BIN   = 1'b1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_INDEX = 1'b1;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  typedef logic [W_W-1:0] rc_rom_t [COS_TABLE_SIZE+1];

  // (1 - cos) / 2 in q0.12 from a q30 taylor series, low half only
  function automatic logic [W_W-1:0] rc_low_half(input longint unsigned k);
    longint unsigned y;
    longint unsigned y2;
    longint unsigned term;
    longint unsigned q;
    longint          acc;
    y    = (PI_Q30 * k) / COS_TABLE_SIZE;
    y2   = (y * y) >> 30;
    term = ONE_Q30;
    acc  = longint'(ONE_Q30);
    // eight alternating terms, divisors (2i-1)*2i
    term = ((term * y2) >> 30) / 64'd2;
    acc  = acc - longint'(term);
    term = ((term * y2) >> 30) / 64'd12;
    acc  = acc + longint'(term);
    term = ((term * y2) >> 30) / 64'd30;
    acc  = acc - longint'(term);
    term = ((term * y2) >> 30) / 64'd56;
    acc  = acc + longint'(term);
    term = ((term * y2) >> 30) / 64'd90;
    acc  = acc - longint'(term);
    term = ((term * y2) >> 30) / 64'd132;
    acc  = acc + longint'(term);
    term = ((term * y2) >> 30) / 64'd182;
    acc  = acc - longint'(term);
    term = ((term * y2) >> 30) / 64'd240;
    acc  = acc + longint'(term);
    if (acc < 0) acc = 0;
    if (acc > longint'(ONE_Q30)) acc = longint'(ONE_Q30);
    q = ((ONE_Q30 - longint'(acc)) + (64'd1 << 18)) >> 19;
    if (q > 64'd4096) q = 64'd4096;
    return W_W'(q);
  endfunction

  function automatic rc_rom_t build_rc_rom();
    rc_rom_t r;
    for (int k = 0; k <= COS_TABLE_SIZE; k++) begin
      if (2 * k <= COS_TABLE_SIZE) r[k] = rc_low_half(longint'(k));
      else r[k] = UNITY_W - rc_low_half(longint'(COS_TABLE_SIZE - k));
    end
    return r;
  endfunction

  localparam rc_rom_t RC_ROM = build_rc_rom();

endpackage

>>> src/egbf_div.sv
// serial divider: floor(num*4096/den) if num < den, one quotient bit a cycle
// else 4096, or 0 for den 0; depends on egbf_pkg and assert_macros.svh
`include "assert_macros.svh"

module egbf_div import egbf_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [F_W-1:0] num_i,
  input  logic [F_W-1:0] den_i,
  output logic           done_o,
  output logic [W_W-1:0] quo_o
);

  logic           run_q, run_d;
  logic           done_q, done_d;
  logic [3:0]     cnt_q, cnt_d;
  logic [F_W:0]   rem_q, rem_d;
  logic [F_W-1:0] den_q, den_d;
  logic [W_W-1:0] quo_q, quo_d;
  logic [F_W:0]   rem2;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    rem2   = {rem_q[F_W-1:0], 1'b0};
    if (start_i) begin
      den_d = den_i;
      if (den_i == '0) begin
        quo_d  = '0;
        done_d = 1'b1;
      end else if (num_i >= den_i) begin
        quo_d  = UNITY_W;
        done_d = 1'b1;
      end else begin
        rem_d = {1'b0, num_i};
        quo_d = '0;
        cnt_d = 4'(FRAC_BITS);
        run_d = 1'b1;
      end
    end else if (run_q) begin
      // remainder stays below den, so the doubled value fits one extra bit
      if (rem2 >= {1'b0, den_q}) begin
        rem_d = rem2 - {1'b0, den_q};
        quo_d = {quo_q[W_W-2:0], 1'b1};
      end else begin
        rem_d = rem2;
        quo_d = {quo_q[W_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 4'd1;
      if (cnt_q == 4'd1) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

  `ASSERT_IMP(div_quo_range, done_o, quo_o <= UNITY_W)
  `ASSERT_IMP(div_rem_below_den, run_q, rem_q < {1'b0, den_q})
  `ASSERT_NXT(div_zero_den, start_i && den_i == '0, done_o && quo_o == '0)

endmodule

>>> src/egbf_mul.sv
// shared unsigned multiplier with a registered product
// depends on egbf_pkg
module egbf_mul import egbf_pkg::*; (
  input  logic               clk_i,
  input  logic [MUL_W-1:0]   a_i,
  input  logic [MUL_W-1:0]   b_i,
  output logic [2*MUL_W-1:0] p_o
);

  logic [2*MUL_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= (2*MUL_W)'(a_i) * (2*MUL_W)'(b_i);
  end

  assign p_o = p_q;

endmodule

>>> src/equalizer_band_gain_filter.sv
// equalizer band gain: a band write beat returns its status in the next cycle.
// a bin beat scans at most the first n band entries, n the band count clamped to [2, MAX_BANDS],
// one band entry a cycle; the interpolating shapes may then run the serial divider, which
// spends one cycle a quotient bit, then up to five products on one multiplier (three in
// rectangular shape). one beat at a time, busy high during a bin beat; results cannot be stalled.
// reset sets rectangular shape, count 2, unity volume, band frequencies 0, gains unity.
`include "assert_macros.svh"

module equalizer_band_gain_filter import egbf_pkg::*; #(
  parameter int MAX_BANDS = MAX_BANDS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  output logic                     done_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [VOL_W-1:0]         cfg_wdata_i,
  input  logic                     kind_i,
  input  logic [3:0]               band_index_i,
  input  logic [FREQ_W-1:0]        band_freq_i,
  input  logic [GAIN_W-1:0]        band_gain_i,
  input  logic [BIN_W-1:0]         bin_index_i,
  input  logic signed [PART_W-1:0] bin_real_i,
  input  logic signed [PART_W-1:0] bin_imag_i,
  output logic                     status_o,
  output logic [GAIN_W-1:0]        bin_gain_o,
  output logic signed [PART_W-1:0] out_real_o,
  output logic signed [PART_W-1:0] out_imag_o,
  output logic                     saturated_o
);

  localparam int IDX_W  = $clog2(MAX_BANDS);
  localparam int CNT_W  = ($clog2(MAX_BANDS + 1) > 5) ? $clog2(MAX_BANDS + 1) : 5;
  localparam int RCI_W  = $clog2(COS_TABLE_SIZE + 1);
  localparam int TC_W   = W_W + RCI_W;
  localparam int P_W    = 2 * MUL_W;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_SCAN = 12'b000000000010,
    S_DST  = 12'b000000000100,
    S_DIV  = 12'b000000001000,
    S_WGT  = 12'b000000010000,
    S_BL1  = 12'b000000100000,
    S_BL2  = 12'b000001000000,
    S_BL3  = 12'b000010000000,
    S_VOL  = 12'b000100000000,
    S_RE   = 12'b001000000000,
    S_IM   = 12'b010000000000,
    S_FIN  = 12'b100000000000
  } state_e;

  typedef struct packed {
    logic [PART_W-1:0] val;
    logic              clip;
  } sat_t;

  // round half away from zero, then clip to the 28 bit range
  function automatic sat_t saturate(input logic [P_W-1:0] p, input logic neg);
    logic [P_W-1:0] s;
    logic [P_W-25:0] r;
    sat_t o;
    s = p + P_W'(64'd1 << 23);
    r = s[P_W-1:24];
    o.clip = 1'b0;
    if (neg) begin
      if (r > (P_W-24)'(64'd1 << 27)) begin
        r = (P_W-24)'(64'd1 << 27);
        o.clip = 1'b1;
      end
      o.val = PART_W'(0) - r[PART_W-1:0];
    end else begin
      if (r > (P_W-24)'((64'd1 << 27) - 64'd1)) begin
        r = (P_W-24)'((64'd1 << 27) - 64'd1);
        o.clip = 1'b1;
      end
      o.val = r[PART_W-1:0];
    end
    return o;
  endfunction

  state_e state_q, state_d;

  logic [1:0]        shape_q;
  logic [4:0]        count_q;
  logic [VOL_W-1:0]  volume_q;
  logic [FREQ_W-1:0] freq_tab_q [MAX_BANDS];
  logic [GAIN_W-1:0] gain_tab_q [MAX_BANDS];

  logic [IDX_W-1:0]  k_q, k_d;
  logic [F_W-1:0]    f_q, f_d, pf_q, pf_d, num_q, num_d, den_q, den_d;
  logic [GAIN_W-1:0] pg_q, pg_d, a_q, a_d, b_q, b_d, g_q, g_d;
  logic              found_q, found_d;
  logic [W_W-1:0]    t_q, t_d, w_q, w_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [MUL_W-1:0]  factor_q, factor_d;
  logic [PART_W-1:0] mre_q, mre_d, mim_q, mim_d;
  logic              nre_q, nre_d, nim_q, nim_d;

  logic              status_q, status_d;
  logic [GAIN_W-1:0] gain_out_q, gain_out_d;
  logic [PART_W-1:0] ore_q, ore_d, oim_q, oim_d;
  logic              sat_q, sat_d;
  logic              done_q, done_d;

  logic              wr_en;
  logic [CNT_W-1:0]  cnt_ext, n_eff;
  logic              last;
  logic [F_W-1:0]    fr;
  logic [GAIN_W-1:0] gr;
  logic              rect, hit, rect_hit;
  logic [BP_W-1:0]   fprod;
  logic [TC_W-1:0]   tc;
  logic [TC_W-1:0]   ridx;
  logic [W_W-1:0]    weight;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [P_W-1:0]    mul_p;
  logic              div_start, div_done;
  logic [W_W-1:0]    div_quo;
  sat_t              sat_re, sat_im;

  egbf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  egbf_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // band count clamped to [2, MAX_BANDS]
  assign cnt_ext = CNT_W'(count_q);
  always_comb begin
    if (cnt_ext < CNT_W'(2)) n_eff = CNT_W'(2);
    else if (cnt_ext > CNT_W'(MAX_BANDS)) n_eff = CNT_W'(MAX_BANDS);
    else n_eff = cnt_ext;
  end

  assign last     = (CNT_W'(k_q) == n_eff - CNT_W'(1));
  assign fr       = F_W'(freq_tab_q[k_q]);
  assign gr       = gain_tab_q[k_q];
  assign rect     = (shape_q != SHAPE_LINEAR) && (shape_q != SHAPE_COSINE);
  assign rect_hit = ({f_q, 1'b0} < ((F_W+1)'(pf_q) + (F_W+1)'(fr)));
  assign hit      = (k_q != '0) && !found_q && (pf_q <= f_q) && (f_q <= fr);
  assign fprod    = BP_W'(bin_index_i) * BP_W'(SAMPLE_RATE_HZ);

  // blend weight: fraction itself or the raised-cosine rom entry
  always_comb begin
    tc   = TC_W'(t_q) * TC_W'(COS_TABLE_SIZE) + TC_W'(2048);
    ridx = tc >> FRAC_BITS;
    if (ridx > TC_W'(COS_TABLE_SIZE)) ridx = TC_W'(COS_TABLE_SIZE);
    if (shape_q == SHAPE_COSINE) weight = RC_ROM[ridx[RCI_W-1:0]];
    else weight = t_q;
  end

  assign sat_re = saturate(mul_p, nre_q);
  assign sat_im = saturate(mul_p, nim_q);

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    f_d        = f_q;
    pf_d       = pf_q;
    pg_d       = pg_q;
    found_d    = found_q;
    a_d        = a_q;
    b_d        = b_q;
    num_d      = num_q;
    den_d      = den_q;
    t_d        = t_q;
    w_d        = w_q;
    acc_d      = acc_q;
    g_d        = g_q;
    factor_d   = factor_q;
    mre_d      = mre_q;
    mim_d      = mim_q;
    nre_d      = nre_q;
    nim_d      = nim_q;
    status_d   = status_q;
    gain_out_d = gain_out_q;
    ore_d      = ore_q;
    oim_d      = oim_q;
    sat_d      = sat_q;
    done_d     = 1'b0;
    wr_en      = 1'b0;
    div_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          if (kind_i == KIND_WRITE) begin
            done_d     = 1'b1;
            gain_out_d = '0;
            ore_d      = '0;
            oim_d      = '0;
            sat_d      = 1'b0;
            if (CNT_W'(band_index_i) < n_eff) begin
              status_d = STATUS_OK;
              wr_en    = 1'b1;
            end else begin
              status_d = STATUS_BAD_INDEX;
            end
          end else begin
            f_d     = F_W'(fprod >> FFT_SHIFT);
            nre_d   = bin_real_i[PART_W-1];
            nim_d   = bin_imag_i[PART_W-1];
            mre_d   = bin_real_i[PART_W-1] ? PART_W'(0) - bin_real_i : bin_real_i;
            mim_d   = bin_imag_i[PART_W-1] ? PART_W'(0) - bin_imag_i : bin_imag_i;
            k_d     = '0;
            found_d = 1'b0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rect) begin
          // first pair whose midpoint lies above f, ties to the upper band
          if (k_q != '0 && rect_hit) begin
            g_d     = pg_q;
            state_d = S_VOL;
          end else if (last) begin
            g_d     = gr;
            state_d = S_VOL;
          end else begin
            k_d  = k_q + IDX_W'(1);
            pf_d = fr;
            pg_d = gr;
          end
        end else if (k_q == '0 && f_q < fr) begin
          // below the first band: blend from unity
          a_d     = UNITY_GAIN;
          b_d     = gr;
          num_d   = f_q;
          den_d   = fr;
          state_d = S_DST;
        end else begin
          if (hit) begin
            a_d     = pg_q;
            b_d     = gr;
            num_d   = f_q - pf_q;
            den_d   = fr - pf_q;
            found_d = 1'b1;
          end
          if (last) begin
            if (f_q > fr) begin
              // above the last band: blend toward unity at nyquist
              a_d = gr;
              b_d = UNITY_GAIN;
              if (fr >= F_W'(NYQ_HZ)) begin
                t_d     = UNITY_W;
                state_d = S_WGT;
              end else begin
                num_d   = f_q - fr;
                den_d   = F_W'(NYQ_HZ) - fr;
                state_d = S_DST;
              end
            end else if (found_q || hit) begin
              state_d = S_DST;
            end else begin
              g_d     = UNITY_GAIN;
              state_d = S_VOL;
            end
          end else begin
            k_d  = k_q + IDX_W'(1);
            pf_d = fr;
            pg_d = gr;
          end
        end
      end
      S_DST: begin
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          t_d     = div_quo;
          state_d = S_WGT;
        end
      end
      S_WGT: begin
        w_d     = weight;
        state_d = S_BL1;
      end
      S_BL1: begin
        mul_a   = MUL_W'(a_q);
        mul_b   = MUL_W'(UNITY_W - w_q);
        state_d = S_BL2;
      end
      S_BL2: begin
        acc_d   = ACC_W'(mul_p);
        mul_a   = MUL_W'(b_q);
        mul_b   = MUL_W'(w_q);
        state_d = S_BL3;
      end
      S_BL3: begin
        g_d     = GAIN_W'(((ACC_W+1)'(acc_q) + (ACC_W+1)'(mul_p[ACC_W-1:0])
                           + (ACC_W+1)'(2048)) >> FRAC_BITS);
        state_d = S_VOL;
      end
      S_VOL: begin
        mul_a   = MUL_W'(volume_q);
        mul_b   = MUL_W'(g_q);
        state_d = S_RE;
      end
      S_RE: begin
        factor_d = mul_p[MUL_W-1:0];
        mul_a    = MUL_W'(mre_q);
        mul_b    = mul_p[MUL_W-1:0];
        state_d  = S_IM;
      end
      S_IM: begin
        ore_d   = sat_re.val;
        sat_d   = sat_re.clip;
        mul_a   = MUL_W'(mim_q);
        mul_b   = factor_q;
        state_d = S_FIN;
      end
      S_FIN: begin
        oim_d      = sat_im.val;
        sat_d      = sat_q | sat_im.clip;
        gain_out_d = g_q;
        status_d   = STATUS_OK;
        done_d     = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      done_q   <= 1'b0;
      shape_q  <= SHAPE_RECT;
      count_q  <= 5'd2;
      volume_q <= VOL_W'(4096);
      for (int i = 0; i < MAX_BANDS; i++) begin
        freq_tab_q[i] <= '0;
        gain_tab_q[i] <= UNITY_GAIN;
      end
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SHAPE:  shape_q  <= cfg_wdata_i[1:0];
          CFG_COUNT:  count_q  <= cfg_wdata_i[4:0];
          CFG_VOLUME: volume_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (wr_en) begin
        freq_tab_q[IDX_W'(band_index_i)] <= band_freq_i;
        gain_tab_q[IDX_W'(band_index_i)] <= band_gain_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      k_q     <= '0;
    end else begin
      found_q <= found_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q        <= f_d;
    pf_q       <= pf_d;
    pg_q       <= pg_d;
    a_q        <= a_d;
    b_q        <= b_d;
    num_q      <= num_d;
    den_q      <= den_d;
    t_q        <= t_d;
    w_q        <= w_d;
    acc_q      <= acc_d;
    g_q        <= g_d;
    factor_q   <= factor_d;
    mre_q      <= mre_d;
    mim_q      <= mim_d;
    nre_q      <= nre_d;
    nim_q      <= nim_d;
    status_q   <= status_d;
    gain_out_q <= gain_out_d;
    ore_q      <= ore_d;
    oim_q      <= oim_d;
    sat_q      <= sat_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign bin_gain_o  = gain_out_q;
  assign out_real_o  = ore_q;
  assign out_imag_o  = oim_q;
  assign saturated_o = sat_q;

  `ASSERT_NXT(bin_beat_goes_busy, start && !busy && kind_i == KIND_BIN, busy && !done_o)
  `ASSERT_IMP(refused_write_zero, done_o && status_o == STATUS_BAD_INDEX,
              bin_gain_o == '0 && !saturated_o)
  `ASSERT_IMP(clip_needs_gain, done_o && saturated_o, bin_gain_o != '0)

endmodule
